### sv/bsh_pkg.sv
// Shared types, sizes and codes for the bucketed sample history block.
// Used by every module of the block; depends on nothing else.
package bsh_pkg;

    localparam int HIST_SLOTS = 32;
    localparam int SLOT_W     = $clog2(HIST_SLOTS);
    localparam int CNT_W      = $clog2(HIST_SLOTS + 1);
    localparam int RESULT_CAP = 32;
    localparam int TOT_W      = 32 + SLOT_W + 1;
    localparam int BSEC_W     = 17;
    localparam int SUM_W      = 48;
    localparam int SAMP_W     = 16;
    localparam int DIVC_W     = $clog2(SUM_W + 1);

    localparam logic [BSEC_W-1:0] BSEC_RESET = BSEC_W'(60);

    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Cell operations: hold, take the newer neighbor, take the older neighbor, clear.
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_NEWER = 2'd1;
    localparam logic [1:0] CELL_OLDER = 2'd2;
    localparam logic [1:0] CELL_CLEAR = 2'd3;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic        [31:0] now;
        logic signed [31:0] value;
        logic        [31:0] start_ago;
        logic        [31:0] end_ago;
        logic        [5:0]  dump_limit;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] stat_min;
        logic signed [31:0] stat_max;
        logic signed [31:0] stat_avg;
        logic signed [31:0] first_value;
        logic signed [31:0] last_value;
        logic        [5:0]  match_count;
        logic signed [31:0] dump_value;
        logic               dump_valid;
        logic               is_last;
    } t_out_word;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [SAMP_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

### sv/bsh_cell.sv
// One slot cell of the history chain: holds one bucket mean.
// Depends on bsh_pkg for the cell operation codes.
module bsh_cell
    import bsh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_from_newer,
    input  logic signed [31:0] i_from_older,
    output logic signed [31:0] o_value
);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        case (i_op)
            CELL_NEWER: n_value = i_from_newer;
            CELL_OLDER: n_value = i_from_older;
            CELL_CLEAR: n_value = '0;
            default:    n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

### sv/bsh_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on bsh_pkg for widths and the request/response structs.
module bsh_div
    import bsh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIVC_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [SAMP_W-1:0] r_rem, n_rem;
    logic [SAMP_W-1:0] r_dvs, n_dvs;
    logic [SAMP_W:0]   w_shift;

    always_comb begin
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        w_shift = {r_rem, r_quo[SUM_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_dvs}) begin
                n_rem = SAMP_W'(w_shift - {1'b0, r_dvs});
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = SAMP_W'(w_shift);
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIVC_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### sv/bucketed_sample_history.sv
// Channel | direction | handshake                 | word
// in      | input     | i_in_valid / o_in_stall   | t_in_word: request and sample
// out     | output    | o_out_valid / i_out_stall | t_out_word: statistics or dump value
// cfg     | input     | i_cfg_we                  | i_cfg_data: bucket length in seconds
//
// One request at a time. A record is taken in the idle state or, when it closes a bucket,
// waits while the 48-bit sum goes through the bit-serial divider. A clear is done in idle.
// A query rotates the 32-cell chain once, then divides when any slot matched.
// A dump rotates to its oldest slot, then emits its words. Reset is synchronous and
// clears every slot cell at once; stalls on the output just hold the sequencer.
module bucketed_sample_history
    import bsh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out,
    input  logic              i_cfg_we,
    input  logic [BSEC_W-1:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_REC_DIV = 4'd1;
    localparam logic [3:0] S_Q_WALK  = 4'd2;
    localparam logic [3:0] S_Q_START = 4'd3;
    localparam logic [3:0] S_Q_DIV   = 4'd4;
    localparam logic [3:0] S_Q_OUT   = 4'd5;
    localparam logic [3:0] S_D_SEEK  = 4'd6;
    localparam logic [3:0] S_D_EMIT  = 4'd7;
    localparam logic [3:0] S_D_NONE  = 4'd8;

    logic [3:0]               r_state, n_state;
    logic [BSEC_W-1:0]        r_bsec, n_bsec;
    logic [CNT_W-1:0]         r_filled, n_filled;
    logic [31:0]              r_nbe, n_nbe;
    logic [31:0]              r_bstart, n_bstart;
    logic signed [SUM_W-1:0]  r_psum, n_psum;
    logic [SAMP_W-1:0]        r_psamp, n_psamp;
    logic [SLOT_W-1:0]        r_step, n_step;
    logic [31:0]              r_age, n_age;
    logic [31:0]              r_start, n_start;
    logic [31:0]              r_end, n_end;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [TOT_W-1:0]  r_total, n_total;
    logic signed [31:0]       r_min, n_min;
    logic signed [31:0]       r_max, n_max;
    logic signed [31:0]       r_first, n_first;
    logic signed [31:0]       r_last, n_last;
    logic signed [31:0]       r_avg, n_avg;
    logic                     r_neg, n_neg;
    logic [CNT_W-1:0]         r_dcount, n_dcount;
    logic                     r_out_valid, n_out_valid;
    t_out_word                r_out, n_out;

    logic [1:0]               w_cell_op;
    logic                     w_push;
    logic signed [31:0]       w_cell [HIST_SLOTS];
    logic signed [31:0]       w_cell0_in;
    logic signed [31:0]       w_head;
    logic                     w_free;
    logic [31:0]              w_bend;
    logic signed [SUM_W-1:0]  w_sample;
    logic signed [SUM_W-1:0]  w_total_ext;
    logic signed [31:0]       w_quo32;
    logic [7:0]               w_dc1, w_dcount;
    logic [SLOT_W-1:0]        w_dlast;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    // The chain: cell 0 holds the newest slot. Pushing and reverse rotation both take
    // the newer neighbor; cell 0 takes a new mean on a push and the last cell otherwise.
    assign w_cell0_in = w_push ? w_quo32 : w_cell[HIST_SLOTS-1];
    assign w_head     = w_cell[0];

    for (genvar g = 0; g < HIST_SLOTS; g++) begin : g_cell
        bsh_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_cell_op),
            .i_from_newer ((g == 0) ? w_cell0_in
                                    : w_cell[(g + HIST_SLOTS - 1) % HIST_SLOTS]),
            .i_from_older (w_cell[(g + 1) % HIST_SLOTS]),
            .o_value      (w_cell[g])
        );
    end

    bsh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_free      = !r_out_valid || !i_out_stall;
    assign w_bend      = r_bstart + 32'(r_bsec);
    assign w_sample    = SUM_W'(i_in.value);
    assign w_total_ext = {{(SUM_W - TOT_W){r_total[TOT_W-1]}}, r_total};
    assign w_quo32     = r_neg ? -w_div_rsp.quotient[31:0] : w_div_rsp.quotient[31:0];
    assign w_dc1       = (8'(r_filled) < 8'(i_in.dump_limit)) ? 8'(r_filled)
                                                               : 8'(i_in.dump_limit);
    assign w_dcount    = (w_dc1 > 8'(RESULT_CAP)) ? 8'(RESULT_CAP) : w_dc1;
    assign w_dlast     = SLOT_W'(r_dcount - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_bsec      = r_bsec;
        n_filled    = r_filled;
        n_nbe       = r_nbe;
        n_bstart    = r_bstart;
        n_psum      = r_psum;
        n_psamp     = r_psamp;
        n_step      = r_step;
        n_age       = r_age;
        n_start     = r_start;
        n_end       = r_end;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_min       = r_min;
        n_max       = r_max;
        n_first     = r_first;
        n_last      = r_last;
        n_avg       = r_avg;
        n_neg       = r_neg;
        n_dcount    = r_dcount;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_cell_op   = CELL_HOLD;
        w_push      = 1'b0;
        w_div_req   = '0;

        if (i_cfg_we) begin
            n_bsec = i_cfg_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in.req_type)
                        REQ_RECORD: begin
                            if (r_psamp == '0) begin
                                n_bstart = i_in.now;
                                n_psum   = w_sample;
                                n_psamp  = SAMP_W'(1);
                            end else if (i_in.now < w_bend) begin
                                // A full bucket ignores further samples.
                                if (r_psamp != '1) begin
                                    n_psum  = r_psum + w_sample;
                                    n_psamp = r_psamp + 1'b1;
                                end
                            end else begin
                                n_nbe              = w_bend;
                                w_div_req.start    = 1'b1;
                                w_div_req.dividend = r_psum[SUM_W-1] ? SUM_W'(-r_psum)
                                                                     : SUM_W'(r_psum);
                                w_div_req.divisor  = r_psamp;
                                n_neg              = r_psum[SUM_W-1];
                                n_bstart           = i_in.now;
                                n_psum             = w_sample;
                                n_psamp            = SAMP_W'(1);
                                n_state            = S_REC_DIV;
                            end
                        end
                        REQ_QUERY: begin
                            n_age   = i_in.now - r_nbe;
                            n_start = i_in.start_ago;
                            n_end   = i_in.end_ago;
                            n_step  = '0;
                            n_cnt   = '0;
                            n_total = '0;
                            n_min   = '0;
                            n_max   = '0;
                            n_first = '0;
                            n_last  = '0;
                            n_state = S_Q_WALK;
                        end
                        REQ_DUMP: begin
                            n_dcount = CNT_W'(w_dcount);
                            n_step   = '0;
                            n_state  = (w_dcount == 8'd0) ? S_D_NONE : S_D_SEEK;
                        end
                        REQ_CLEAR: begin
                            w_cell_op = CELL_CLEAR;
                            n_filled  = '0;
                            n_nbe     = '0;
                            n_bstart  = '0;
                            n_psum    = '0;
                            n_psamp   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_REC_DIV: begin
                if (w_div_rsp.done) begin
                    w_push    = 1'b1;
                    w_cell_op = CELL_NEWER;
                    if (r_filled != CNT_W'(HIST_SLOTS)) begin
                        n_filled = r_filled + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_Q_WALK: begin
                // Cell 0 shows the slot r_step places back from the newest.
                w_cell_op = CELL_OLDER;
                if ((CNT_W'(r_step) < r_filled) && (r_age >= r_end) && (r_age < r_start)) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_total = r_total + TOT_W'(w_head);
                    if (r_cnt == '0) begin
                        n_min  = w_head;
                        n_max  = w_head;
                        n_last = w_head;
                    end else begin
                        if (w_head < r_min) n_min = w_head;
                        if (w_head > r_max) n_max = w_head;
                    end
                    n_first = w_head;
                end
                n_age  = r_age + 32'(r_bsec);
                n_step = r_step + 1'b1;
                if (r_step == SLOT_W'(HIST_SLOTS - 1)) begin
                    n_state = S_Q_START;
                end
            end
            S_Q_START: begin
                if (r_cnt == '0) begin
                    n_avg   = '0;
                    n_state = S_Q_OUT;
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = r_total[TOT_W-1] ? SUM_W'(-w_total_ext)
                                                          : SUM_W'(w_total_ext);
                    w_div_req.divisor  = SAMP_W'(r_cnt);
                    n_neg              = r_total[TOT_W-1];
                    n_state            = S_Q_DIV;
                end
            end
            S_Q_DIV: begin
                if (w_div_rsp.done) begin
                    n_avg   = w_quo32;
                    n_state = S_Q_OUT;
                end
            end
            S_Q_OUT: begin
                if (w_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.stat_min    = r_min;
                    n_out.stat_max    = r_max;
                    n_out.stat_avg    = r_avg;
                    n_out.first_value = r_first;
                    n_out.last_value  = r_last;
                    n_out.match_count = 6'(r_cnt);
                    n_out.is_last     = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_D_SEEK: begin
                // Rotate until cell 0 holds the oldest slot of the dump.
                if (r_step == w_dlast) begin
                    n_state = S_D_EMIT;
                end else begin
                    w_cell_op = CELL_OLDER;
                    n_step    = r_step + 1'b1;
                end
            end
            S_D_EMIT: begin
                if (w_free) begin
                    n_out_valid      = 1'b1;
                    n_out            = '0;
                    n_out.dump_value = w_head;
                    n_out.dump_valid = 1'b1;
                    if (r_step == '0) begin
                        n_out.is_last = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        w_cell_op = CELL_NEWER;
                        n_step    = r_step - 1'b1;
                    end
                end
            end
            S_D_NONE: begin
                if (w_free) begin
                    n_out_valid   = 1'b1;
                    n_out         = '0;
                    n_out.is_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bsec      <= BSEC_RESET;
            r_filled    <= '0;
            r_nbe       <= '0;
            r_bstart    <= '0;
            r_psum      <= '0;
            r_psamp     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bsec      <= n_bsec;
            r_filled    <= n_filled;
            r_nbe       <= n_nbe;
            r_bstart    <= n_bstart;
            r_psum      <= n_psum;
            r_psamp     <= n_psamp;
            r_out_valid <= n_out_valid;
        end
        r_step   <= n_step;
        r_age    <= n_age;
        r_start  <= n_start;
        r_end    <= n_end;
        r_cnt    <= n_cnt;
        r_total  <= n_total;
        r_min    <= n_min;
        r_max    <= n_max;
        r_first  <= n_first;
        r_last   <= n_last;
        r_avg    <= n_avg;
        r_neg    <= n_neg;
        r_dcount <= n_dcount;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### sv/bsh_checker.sv
// Port-level checks for bucketed_sample_history, attached by the bind below.
// Depends on bsh_pkg for the word types and sizes.
module bsh_checker
    import bsh_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input t_in_word          i_in,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_word         o_out
);

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output word changed while stalled");

    // Statistics words are always the single, final word of their request.
    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.dump_valid |-> o_out.is_last)
        else $error("statistics word not marked last");

    // Dump words carry no statistics.
    a_dump_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.dump_valid |-> o_out.match_count == '0 && o_out.stat_avg == '0)
        else $error("dump word carries statistics");

    // A query or dump keeps the input stalled while it runs.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (i_in.req_type == REQ_QUERY || i_in.req_type == REQ_DUMP) |=> o_in_stall)
        else $error("input taken while a request is in progress");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.match_count <= 6'(HIST_SLOTS))
        else $error("match count above slot count");

endmodule

bind bucketed_sample_history bsh_checker u_bsh_checker (.*);
